// File: sv/pfrs_pkg.sv
// Package for the PID gain-schedule Routh-Hurwitz screen.
// Holds widths, codes, the micro-op type and the fixed micro-op schedule.
// No dependencies.
package pfrs_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int CNT_W       = $clog2(MAX_ENTRIES);

   localparam int GAIN_W      = 32;
   localparam int NUM_GAINS   = 6;
   localparam int REQ_DATA_W  = GAIN_W * NUM_GAINS;
   localparam int ENTRY_W     = 8;
   localparam int VERDICT_W   = 2;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - ENTRY_W - VERDICT_W - 1;

   localparam int LIMB_W      = 32;
   localparam int MUL_W       = LIMB_W + 1;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int WIDE_W      = 2 * GAIN_W;
   localparam int COEF_LIMBS  = 3;
   localparam int COEF_W      = COEF_LIMBS * LIMB_W;
   localparam int ACC_W       = 200;

   localparam int C2_ONE_POS  = 49;
   localparam int C2_KP_SHIFT = 17;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] CHECK_STEP = 5'd9;
   localparam logic [STEP_W-1:0] LAST_STEP  = 5'd24;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_STABLE   = 2'd0,
      VERDICT_UNSTABLE = 2'd1,
      VERDICT_SKIPPED  = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      OPA_NONE,
      OPA_K,
      OPA_T,
      OPA_PKD_LO,
      OPA_PKD_HI,
      OPA_PKI_LO,
      OPA_PKI_HI,
      OPA_C1,
      OPA_C0
   } opa_type;

   typedef enum logic [2:0] {
      OPB_NONE,
      OPB_KD,
      OPB_KP,
      OPB_KI,
      OPB_L,
      OPB_NEG_L,
      OPB_C2,
      OPB_NEG_C3
   } opb_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_PKD,
      DST_PKP,
      DST_PKI,
      DST_C0,
      DST_ACC
   } dst_type;

   typedef enum logic [1:0] {
      BASE_ACC,
      BASE_ZERO,
      BASE_C1,
      BASE_C2
   } base_type;

   typedef struct packed {
      dst_type    dst;
      base_type   base;
      logic [2:0] shift;
   } cons_type;

   typedef struct packed {
      opa_type    opa;
      logic [1:0] a_limb;
      opb_type    opb;
      logic [1:0] b_limb;
      logic       save_c1;
      logic       save_c2;
      cons_type   cons;
   } uop_type;

   localparam cons_type CONS_NONE = '{dst: DST_NONE, base: BASE_ACC, shift: 3'd0};

   function automatic uop_type mk(opa_type opa, logic [1:0] a_limb, opb_type opb,
                                  logic [1:0] b_limb, dst_type dst, base_type base,
                                  logic [2:0] shift, logic save_c1, logic save_c2);
      uop_type u;
      u.opa        = opa;
      u.a_limb     = a_limb;
      u.opb        = opb;
      u.b_limb     = b_limb;
      u.save_c1    = save_c1;
      u.save_c2    = save_c2;
      u.cons.dst   = dst;
      u.cons.base  = base;
      u.cons.shift = shift;
      return u;
   endfunction

   // issue A x B in this step, consume the registered product in the next step
   function automatic uop_type uop_at(logic [STEP_W-1:0] step);
      uop_type u;
      unique case (step)
         5'd0:  u = mk(OPA_K,      2'd0, OPB_KD,     2'd0, DST_PKD, BASE_ACC,  3'd0, 1'b0, 1'b0);
         5'd1:  u = mk(OPA_K,      2'd0, OPB_KP,     2'd0, DST_PKP, BASE_ACC,  3'd0, 1'b0, 1'b0);
         5'd2:  u = mk(OPA_K,      2'd0, OPB_KI,     2'd0, DST_PKI, BASE_ACC,  3'd0, 1'b0, 1'b0);
         5'd3:  u = mk(OPA_T,      2'd0, OPB_L,      2'd0, DST_C0,  BASE_ACC,  3'd0, 1'b0, 1'b0);
         5'd4:  u = mk(OPA_PKD_LO, 2'd0, OPB_NEG_L,  2'd0, DST_ACC, BASE_C1,   3'd0, 1'b0, 1'b0);
         5'd5:  u = mk(OPA_PKD_HI, 2'd0, OPB_NEG_L,  2'd0, DST_ACC, BASE_ACC,  3'd1, 1'b0, 1'b0);
         5'd6:  u = mk(OPA_PKI_LO, 2'd0, OPB_NEG_L,  2'd0, DST_ACC, BASE_C2,   3'd0, 1'b0, 1'b0);
         5'd7:  u = mk(OPA_PKI_HI, 2'd0, OPB_NEG_L,  2'd0, DST_ACC, BASE_ACC,  3'd1, 1'b1, 1'b0);
         5'd8:  u = mk(OPA_NONE,   2'd0, OPB_NONE,   2'd0, DST_NONE, BASE_ACC, 3'd0, 1'b0, 1'b0);
         5'd9:  u = mk(OPA_NONE,   2'd0, OPB_NONE,   2'd0, DST_NONE, BASE_ACC, 3'd0, 1'b0, 1'b1);
         5'd10: u = mk(OPA_C1,     2'd0, OPB_C2,     2'd0, DST_ACC, BASE_ZERO, 3'd0, 1'b0, 1'b0);
         5'd11: u = mk(OPA_C1,     2'd0, OPB_C2,     2'd1, DST_ACC, BASE_ACC,  3'd1, 1'b0, 1'b0);
         5'd12: u = mk(OPA_C1,     2'd0, OPB_C2,     2'd2, DST_ACC, BASE_ACC,  3'd2, 1'b0, 1'b0);
         5'd13: u = mk(OPA_C1,     2'd1, OPB_C2,     2'd0, DST_ACC, BASE_ACC,  3'd1, 1'b0, 1'b0);
         5'd14: u = mk(OPA_C1,     2'd1, OPB_C2,     2'd1, DST_ACC, BASE_ACC,  3'd2, 1'b0, 1'b0);
         5'd15: u = mk(OPA_C1,     2'd1, OPB_C2,     2'd2, DST_ACC, BASE_ACC,  3'd3, 1'b0, 1'b0);
         5'd16: u = mk(OPA_C1,     2'd2, OPB_C2,     2'd0, DST_ACC, BASE_ACC,  3'd2, 1'b0, 1'b0);
         5'd17: u = mk(OPA_C1,     2'd2, OPB_C2,     2'd1, DST_ACC, BASE_ACC,  3'd3, 1'b0, 1'b0);
         5'd18: u = mk(OPA_C1,     2'd2, OPB_C2,     2'd2, DST_ACC, BASE_ACC,  3'd4, 1'b0, 1'b0);
         5'd19: u = mk(OPA_C0,     2'd0, OPB_NEG_C3, 2'd0, DST_ACC, BASE_ACC,  3'd1, 1'b0, 1'b0);
         5'd20: u = mk(OPA_C0,     2'd0, OPB_NEG_C3, 2'd1, DST_ACC, BASE_ACC,  3'd2, 1'b0, 1'b0);
         5'd21: u = mk(OPA_C0,     2'd1, OPB_NEG_C3, 2'd0, DST_ACC, BASE_ACC,  3'd2, 1'b0, 1'b0);
         5'd22: u = mk(OPA_C0,     2'd1, OPB_NEG_C3, 2'd1, DST_ACC, BASE_ACC,  3'd3, 1'b0, 1'b0);
         default: u = mk(OPA_NONE, 2'd0, OPB_NONE,   2'd0, DST_NONE, BASE_ACC, 3'd0, 1'b0, 1'b0);
      endcase
      return u;
   endfunction

   function automatic logic acc_positive(logic signed [ACC_W-1:0] a);
      return !a[ACC_W-1] && (a != '0);
   endfunction

endpackage

// File: sv/pid_fopdt_routh_screen_top.sv
// Top level of the PID gain-schedule Routh-Hurwitz screen.
// Depends on pfrs_pkg (widths, codes, micro-op schedule).
//
// One schedule entry is taken per req beat and yields one rsp beat. An entry with a
// non-positive plant gain or time constant, or a negative delay, is reported as skipped
// straight from acceptance. Any other entry runs through a 25-step schedule on a
// single 33x33 signed multiplier feeding a 200-bit accumulator: the coefficient products,
// the four positivity checks at step 9 (a failing entry leaves there as unstable) and
// the limb-wise a1*a2 - a0*a3 compare. The multiplier is the only multiplier in the
// block; an adder sums its products into the accumulator. The block takes no new
// entry while one is in progress; a finished rsp beat waits in its output register while
// the next entry is accepted.
module pid_fopdt_routh_screen_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // prop_gain, integ_gain, deriv_gain, plant_gain, time_const, dead_time (32 bits each)
   input  logic [pfrs_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // entry_index [7:0], verdict [9:8], stable_flag [10], zero [15:11]
   output logic [pfrs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int GW = pfrs_pkg::GAIN_W;
   localparam int LW = pfrs_pkg::LIMB_W;
   localparam int VLO = pfrs_pkg::ENTRY_W;
   localparam int SPOS = pfrs_pkg::ENTRY_W + pfrs_pkg::VERDICT_W;

   pfrs_pkg::state_type   state_ff, state_in;
   logic [pfrs_pkg::STEP_W-1:0] step_ff, step_in;
   pfrs_pkg::uop_type     uop;
   pfrs_pkg::cons_type    cons_ff, cons_in;

   logic signed [GW-1:0]  kp_ff, ki_ff, kd_ff, k_ff, t_ff, l_ff;
   logic signed [GW-1:0]  kp_in, ki_in, kd_in, k_in, t_in, l_in;
   logic signed [GW-1:0]  req_kp, req_ki, req_kd, req_k, req_t, req_l;
   logic                  last_ff, last_in;
   pfrs_pkg::verdict_type verdict_ff, verdict_in;

   logic signed [pfrs_pkg::WIDE_W-1:0] p_kd_ff, p_kp_ff, p_ki_ff;
   logic signed [pfrs_pkg::WIDE_W-1:0] p_kd_in, p_kp_in, p_ki_in;
   logic [1:0][LW-1:0]    c0_ff, c0_in;
   logic [1:0][LW-1:0]    c3_w;
   logic [pfrs_pkg::COEF_LIMBS-1:0][LW-1:0] c1_ff, c1_in, c2_ff, c2_in;
   logic                  c1_pos_ff, c1_pos_in;

   logic signed [pfrs_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [pfrs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [pfrs_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [pfrs_pkg::ACC_W-1:0]  prod_ext, prod_sh, base_val, c1_base, c2_base;
   logic signed [GW+1:0]               tl_sum;

   logic [pfrs_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                  stable_ff, stable_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [pfrs_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   logic                  plant_ok, coef_ok, take, run, emit, stable_flag_w;

   assign req_kp = req_tdata[0*GW +: GW];
   assign req_ki = req_tdata[1*GW +: GW];
   assign req_kd = req_tdata[2*GW +: GW];
   assign req_k  = req_tdata[3*GW +: GW];
   assign req_t  = req_tdata[4*GW +: GW];
   assign req_l  = req_tdata[5*GW +: GW];

   assign plant_ok = !req_k[GW-1] && (req_k != '0) && !req_t[GW-1] && (req_t != '0)
                     && !req_l[GW-1];

   assign uop  = pfrs_pkg::uop_at(step_ff);
   assign c3_w = {p_ki_ff[pfrs_pkg::WIDE_W-2:0], 1'b0};

   assign coef_ok = c1_pos_ff && pfrs_pkg::acc_positive(acc_ff) && (c0_ff != '0)
                    && !p_ki_ff[pfrs_pkg::WIDE_W-1] && (p_ki_ff != '0);

   always_comb begin : fsm_next
      state_in = state_ff;
      unique case (state_ff)
         pfrs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = plant_ok ? pfrs_pkg::ST_RUN : pfrs_pkg::ST_EMIT;
         end
         pfrs_pkg::ST_RUN: begin
            if ((step_ff == pfrs_pkg::CHECK_STEP && !coef_ok) ||
                step_ff == pfrs_pkg::LAST_STEP) state_in = pfrs_pkg::ST_EMIT;
         end
         pfrs_pkg::ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = pfrs_pkg::ST_IDLE;
         end
         default: state_in = pfrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin : fsm_out
      req_tready = (state_ff == pfrs_pkg::ST_IDLE);
      take       = req_tvalid && req_tready;
      run        = (state_ff == pfrs_pkg::ST_RUN);
      emit       = (state_ff == pfrs_pkg::ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);
   end

   always_comb begin : operand_mux
      unique case (uop.opa)
         pfrs_pkg::OPA_K:      mul_a = pfrs_pkg::MUL_W'(k_ff);
         pfrs_pkg::OPA_T:      mul_a = pfrs_pkg::MUL_W'(t_ff);
         pfrs_pkg::OPA_PKD_LO: mul_a = {1'b0, p_kd_ff[LW-1:0]};
         pfrs_pkg::OPA_PKD_HI: mul_a = pfrs_pkg::MUL_W'(signed'(p_kd_ff[pfrs_pkg::WIDE_W-1:LW]));
         pfrs_pkg::OPA_PKI_LO: mul_a = {1'b0, p_ki_ff[LW-1:0]};
         pfrs_pkg::OPA_PKI_HI: mul_a = pfrs_pkg::MUL_W'(signed'(p_ki_ff[pfrs_pkg::WIDE_W-1:LW]));
         pfrs_pkg::OPA_C1:     mul_a = {1'b0, c1_ff[uop.a_limb]};
         pfrs_pkg::OPA_C0:     mul_a = {1'b0, c0_ff[uop.a_limb[0]]};
         default:              mul_a = '0;
      endcase
      unique case (uop.opb)
         pfrs_pkg::OPB_KD:     mul_b = pfrs_pkg::MUL_W'(kd_ff);
         pfrs_pkg::OPB_KP:     mul_b = pfrs_pkg::MUL_W'(kp_ff);
         pfrs_pkg::OPB_KI:     mul_b = pfrs_pkg::MUL_W'(ki_ff);
         pfrs_pkg::OPB_L:      mul_b = pfrs_pkg::MUL_W'(l_ff);
         pfrs_pkg::OPB_NEG_L:  mul_b = -pfrs_pkg::MUL_W'(l_ff);
         pfrs_pkg::OPB_C2:     mul_b = {1'b0, c2_ff[uop.b_limb]};
         pfrs_pkg::OPB_NEG_C3: mul_b = -pfrs_pkg::MUL_W'({1'b0, c3_w[uop.b_limb[0]]});
         default:              mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin : accumulate
      tl_sum   = {t_ff[GW-1], t_ff, 1'b0} + {{2{l_ff[GW-1]}}, l_ff};
      c1_base  = pfrs_pkg::ACC_W'(tl_sum) <<< LW;
      c2_base  = (pfrs_pkg::ACC_W'(p_kp_ff) <<< pfrs_pkg::C2_KP_SHIFT)
                 + (pfrs_pkg::ACC_W'(1) <<< pfrs_pkg::C2_ONE_POS);
      prod_ext = pfrs_pkg::ACC_W'(prod_ff);
      prod_sh  = prod_ext <<< {cons_ff.shift, 5'b0};
      unique case (cons_ff.base)
         pfrs_pkg::BASE_ACC:  base_val = acc_ff;
         pfrs_pkg::BASE_ZERO: base_val = '0;
         pfrs_pkg::BASE_C1:   base_val = c1_base;
         pfrs_pkg::BASE_C2:   base_val = c2_base;
         default:             base_val = acc_ff;
      endcase
      acc_in = (cons_ff.dst == pfrs_pkg::DST_ACC) ? base_val + prod_sh : acc_ff;
   end

   always_comb begin : datapath_next
      step_in    = run ? step_ff + pfrs_pkg::STEP_W'(1) : '0;
      cons_in    = run ? uop.cons : pfrs_pkg::CONS_NONE;
      kp_in      = take ? req_kp : kp_ff;
      ki_in      = take ? req_ki : ki_ff;
      kd_in      = take ? req_kd : kd_ff;
      k_in       = take ? req_k  : k_ff;
      t_in       = take ? req_t  : t_ff;
      l_in       = take ? req_l  : l_ff;
      last_in    = take ? req_tlast : last_ff;

      verdict_in = verdict_ff;
      if (take && !plant_ok) begin
         verdict_in = pfrs_pkg::VERDICT_SKIPPED;
      end else if (run && step_ff == pfrs_pkg::CHECK_STEP && !coef_ok) begin
         verdict_in = pfrs_pkg::VERDICT_UNSTABLE;
      end else if (run && step_ff == pfrs_pkg::LAST_STEP) begin
         verdict_in = pfrs_pkg::acc_positive(acc_ff) ? pfrs_pkg::VERDICT_STABLE
                                                     : pfrs_pkg::VERDICT_UNSTABLE;
      end

      p_kd_in = (cons_ff.dst == pfrs_pkg::DST_PKD) ? prod_ff[pfrs_pkg::WIDE_W-1:0] : p_kd_ff;
      p_kp_in = (cons_ff.dst == pfrs_pkg::DST_PKP) ? prod_ff[pfrs_pkg::WIDE_W-1:0] : p_kp_ff;
      p_ki_in = (cons_ff.dst == pfrs_pkg::DST_PKI) ? prod_ff[pfrs_pkg::WIDE_W-1:0] : p_ki_ff;
      c0_in   = (cons_ff.dst == pfrs_pkg::DST_C0)  ? prod_ff[pfrs_pkg::WIDE_W-1:0] : c0_ff;

      c1_in     = (run && uop.save_c1) ? acc_ff[pfrs_pkg::COEF_W-1:0] : c1_ff;
      c1_pos_in = (run && uop.save_c1) ? pfrs_pkg::acc_positive(acc_ff) : c1_pos_ff;
      c2_in     = (run && uop.save_c2) ? acc_ff[pfrs_pkg::COEF_W-1:0] : c2_ff;

      stable_flag_w = stable_ff && (verdict_ff != pfrs_pkg::VERDICT_UNSTABLE);
      idx_in        = idx_ff;
      stable_in     = stable_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = last_ff;
         rsp_tdata_in  = {pfrs_pkg::RSP_PAD_W'(0), stable_flag_w, verdict_ff,
                          pfrs_pkg::ENTRY_W'(idx_ff)};
         if (last_ff) begin
            idx_in    = '0;
            stable_in = 1'b1;
         end else begin
            idx_in    = (idx_ff == pfrs_pkg::CNT_W'(pfrs_pkg::MAX_ENTRIES - 1)) ?
                        '0 : idx_ff + pfrs_pkg::CNT_W'(1);
            stable_in = stable_flag_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfrs_pkg::ST_IDLE;
         step_ff       <= '0;
         cons_ff       <= pfrs_pkg::CONS_NONE;
         idx_ff        <= '0;
         stable_ff     <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cons_ff       <= cons_in;
         idx_ff        <= idx_in;
         stable_ff     <= stable_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kp_ff        <= kp_in;
      ki_ff        <= ki_in;
      kd_ff        <= kd_in;
      k_ff         <= k_in;
      t_ff         <= t_in;
      l_ff         <= l_in;
      last_ff      <= last_in;
      verdict_ff   <= verdict_in;
      p_kd_ff      <= p_kd_in;
      p_kp_ff      <= p_kp_in;
      p_ki_ff      <= p_ki_in;
      c0_ff        <= c0_in;
      c1_ff        <= c1_in;
      c1_pos_ff    <= c1_pos_in;
      c2_ff        <= c2_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   a_skip_direct: assert property (@(posedge clock) disable iff (reset)
      take && !plant_ok |=> state_ff == pfrs_pkg::ST_EMIT
                            && verdict_ff == pfrs_pkg::VERDICT_SKIPPED)
      else $error("skipped entry did not go straight to emit");

   a_unstable_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[SPOS-1:VLO] == pfrs_pkg::VERDICT_UNSTABLE |-> !rsp_tdata[SPOS])
      else $error("unstable beat kept the table stable flag set");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfrs_pkg::ST_RUN |-> step_ff <= pfrs_pkg::LAST_STEP)
      else $error("sequencer step ran past the schedule");

   a_idle_no_work: assert property (@(posedge clock) disable iff (reset)
      state_ff != pfrs_pkg::ST_RUN |=> cons_ff.dst == pfrs_pkg::DST_NONE)
      else $error("datapath written outside of a run");

endmodule

// File: sim/tb_pid_fopdt_routh_screen_top.sv
// Testbench for pid_fopdt_routh_screen_top: streams gain-schedule entries with random
// gaps and output stalls and checks each verdict beat against an exact 256-bit predictor.
// Depends on pfrs_pkg and the RTL top level; reads no files.
module tb_pid_fopdt_routh_screen_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GW             = pfrs_pkg::GAIN_W;
   localparam int EW             = pfrs_pkg::ENTRY_W;
   localparam int VW             = pfrs_pkg::VERDICT_W;
   localparam int DW             = pfrs_pkg::RSP_DATA_W;
   localparam int ONE            = 65536;
   localparam int GAP_MAX        = 18;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_ITEMS   = 550;
   localparam int LONG_TABLE     = 270;
   localparam int REPORT_MAX     = 10;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [GW-1:0] kp;
      logic signed [GW-1:0] ki;
      logic signed [GW-1:0] kd;
      logic signed [GW-1:0] k;
      logic signed [GW-1:0] tc;
      logic signed [GW-1:0] dt;
      logic                 last;
   } sched_entry_type;

   typedef struct {
      logic [EW-1:0]         idx;
      pfrs_pkg::verdict_type verdict;
      logic                  stable_flag;
      logic                  last;
   } screen_result_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // prop_gain, integ_gain, deriv_gain, plant_gain, time_const, dead_time (32 bits each)
   logic [pfrs_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // entry_index [7:0], verdict [9:8], stable_flag [10], zero [15:11]
   logic [DW-1:0]                   rsp_tdata;
   logic                            rsp_tlast;

   sched_entry_type   schedule_queue[$];
   screen_result_type verdict_queue[$];

   int   tbl_count   = 0;
   logic tbl_stable  = 1'b1;
   int   fail_count  = 0;
   int   req_gap     = 0;
   int   rsp_stall   = 0;
   int   idle_cycles = 0;
   logic req_burst   = 1'b0;
   logic rsp_burst   = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pid_fopdt_routh_screen_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   function automatic logic cubic_is_stable(sched_entry_type e);
      wide_type kp, ki, kd, k, tc, dt, two32, c0, c1, c2, c3;
      kp    = e.kp;
      ki    = e.ki;
      kd    = e.kd;
      k     = e.k;
      tc    = e.tc;
      dt    = e.dt;
      two32 = 256'sh1_0000_0000;
      c0    = tc * dt;
      c1    = 2 * tc * two32 + dt * two32 - k * kd * dt;
      c2    = 256'sh2_0000_0000_0000 + k * kp * 256'sh2_0000 - k * ki * dt;
      c3    = 2 * k * ki;
      if (c0 <= 0 || c1 <= 0 || c2 <= 0 || c3 <= 0)
         return 1'b0;
      return (c1 * c2) > (c0 * c3 * two32);
   endfunction

   function automatic screen_result_type screen_entry(sched_entry_type e);
      screen_result_type r;
      if (e.k <= 0 || e.tc <= 0 || e.dt < 0) begin
         r.verdict = pfrs_pkg::VERDICT_SKIPPED;
      end else if (cubic_is_stable(e)) begin
         r.verdict = pfrs_pkg::VERDICT_STABLE;
      end else begin
         r.verdict  = pfrs_pkg::VERDICT_UNSTABLE;
         tbl_stable = 1'b0;
      end
      r.idx         = tbl_count[EW-1:0];
      r.stable_flag = tbl_stable;
      r.last        = e.last;
      if (e.last) begin
         tbl_count  = 0;
         tbl_stable = 1'b1;
      end else begin
         tbl_count = (tbl_count + 1 >= pfrs_pkg::MAX_ENTRIES) ? 0 : tbl_count + 1;
      end
      return r;
   endfunction

   function automatic int draw_idle(inout logic burst);
      int n;
      n = burst ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 39) == 0)
         burst = !burst;
      return n;
   endfunction

   function automatic sched_entry_type random_entry(logic last);
      sched_entry_type e;
      int              pick;
      pick = $urandom_range(0, 99);
      e.k  = $urandom_range(1, 8 * ONE);
      e.tc = $urandom_range(1, 40 * ONE);
      e.dt = $urandom_range(0, 4 * ONE);
      e.kp = int'($urandom_range(0, 24 * ONE)) - 4 * ONE;
      e.ki = int'($urandom_range(0, 6 * ONE)) - ONE / 2;
      e.kd = int'($urandom_range(0, 5 * ONE)) - ONE;
      if (pick >= 70 && pick < 85) begin
         e.kp = $urandom;
         e.ki = $urandom;
         e.kd = $urandom;
      end else if (pick >= 85 && pick < 95) begin
         e.kp = $urandom;
         e.ki = $urandom;
         e.kd = $urandom;
         e.k  = $urandom;
         e.tc = $urandom;
         e.dt = $urandom;
      end else if (pick >= 95) begin
         case ($urandom_range(0, 2))
            0:       e.k  = -int'($urandom_range(0, ONE));
            1:       e.tc = -int'($urandom_range(0, ONE));
            default: e.dt = -int'($urandom_range(1, ONE));
         endcase
      end
      e.last = last;
      return e;
   endfunction

   task automatic queue_entry(logic signed [GW-1:0] kp, logic signed [GW-1:0] ki,
                              logic signed [GW-1:0] kd, logic signed [GW-1:0] k,
                              logic signed [GW-1:0] tc, logic signed [GW-1:0] dt,
                              logic last);
      sched_entry_type e;
      e = '{kp: kp, ki: ki, kd: kd, k: k, tc: tc, dt: dt, last: last};
      schedule_queue.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap     = draw_idle(req_burst);
         tbl_count   = 0;
         tbl_stable  = 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_queue.push_back(screen_entry(schedule_queue.pop_front()));
            req_gap = draw_idle(req_burst);
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (schedule_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {schedule_queue[0].dt, schedule_queue[0].tc, schedule_queue[0].k,
                              schedule_queue[0].kd, schedule_queue[0].ki, schedule_queue[0].kp};
               req_tlast  <= schedule_queue[0].last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      screen_result_type want;
      logic              beat;
      beat = rsp_tvalid && rsp_tready;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall   = draw_idle(rsp_burst);
      end else begin
         if (beat) begin
            if (verdict_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected rsp beat: data %h last %b", rsp_tdata, rsp_tlast);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_tdata[EW-1:0] !== want.idx ||
                   rsp_tdata[EW+VW-1:EW] !== want.verdict ||
                   rsp_tdata[EW+VW] !== want.stable_flag ||
                   rsp_tdata[DW-1:EW+VW+1] !== '0 ||
                   rsp_tlast !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("rsp mismatch: expected index %0d verdict %0d stable %b last %b, %s",
                              want.idx, want.verdict, want.stable_flag, want.last,
                              $sformatf("got data %h last %b", rsp_tdata, rsp_tlast));
               end
            end
            rsp_stall = draw_idle(rsp_burst);
         end
         if (beat || !rsp_tready) begin
            if (rsp_stall > 0) begin
               rsp_stall--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int made;
      int tables;
      int len;
      queue_entry(ONE, 6554, 0, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, 6554, 0, ONE, 10 * ONE, 0, 1'b0);
      queue_entry(ONE, 6554, 0, 0, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, 6554, 0, 32'sh8000_0000, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, 6554, 0, ONE, 0, ONE, 1'b0);
      queue_entry(ONE, 6554, 0, ONE, -1, ONE, 1'b0);
      queue_entry(ONE, 6554, 0, ONE, 10 * ONE, -1, 1'b1);
      queue_entry(10 * ONE, 2 * ONE, 19 * ONE, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(10 * ONE + 1, 2 * ONE, 19 * ONE, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(20 * ONE, 10 * ONE, 19 * ONE, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, ONE, 100 * ONE, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, -ONE, 0, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(ONE, 0, 0, ONE, 10 * ONE, ONE, 1'b0);
      queue_entry(0, 10 * ONE, 0, ONE, ONE, ONE, 1'b1);
      queue_entry(ONE, 6554, 0, ONE, 10 * ONE, ONE, 1'b1);
      queue_entry(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
      queue_entry(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
      queue_entry(32'sh7fff_ffff, 1, 32'sh8000_0000, 1, 1, 1, 1'b0);
      queue_entry(ONE, ONE / 4, -2 * ONE, 32'sh7fff_ffff, ONE, 32'sh7fff_ffff, 1'b0);
      queue_entry(2 * ONE, ONE / 2, -ONE, 2 * ONE, 5 * ONE, ONE / 2, 1'b1);
      made   = 0;
      tables = 0;
      while (made < RANDOM_ITEMS) begin
         len = (tables == 1) ? LONG_TABLE : $urandom_range(1, 24);
         for (int i = 0; i < len; i++)
            schedule_queue.push_back(random_entry(i == len - 1));
         made += len;
         tables++;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (schedule_queue.size() != 0 || verdict_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
